// File: rtl/olist_pkg.sv
// Package with sizes, command codes, status codes and pointer helpers of the list engine.
package olist_pkg;

  // Store geometry.
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Field widths of the channels.
  localparam int KIND_W = 3;
  localparam int STAT_W = 3;
  localparam int POS_W  = 4;

  typedef logic [KIND_W-1:0]            kind_t;
  typedef logic [STAT_W-1:0]            stat_t;
  typedef logic signed [DATA_WIDTH-1:0] word_t;
  typedef logic [IDX_W-1:0]             idx_t;
  typedef logic [CNT_W-1:0]             cnt_t;
  typedef logic [POS_W-1:0]             pos_t;

  // Command codes.
  localparam kind_t K_INS_HEAD = 3'd0;
  localparam kind_t K_DEL_HEAD = 3'd1;
  localparam kind_t K_DEL_TAIL = 3'd2;
  localparam kind_t K_DEL_AFT  = 3'd3;
  localparam kind_t K_DEL_BEF  = 3'd4;
  localparam kind_t K_SEARCH   = 3'd5;

  // Status codes.
  localparam stat_t ST_OK        = 3'd0;
  localparam stat_t ST_UNDERFLOW = 3'd1;
  localparam stat_t ST_NOTFOUND  = 3'd2;
  localparam stat_t ST_NONEIGH   = 3'd3;
  localparam stat_t ST_FULL      = 3'd4;

  // Step a physical store index forwards, wrapping at the end of the store.
  function automatic idx_t idx_inc(input idx_t a);
    return (a == IDX_W'(DEPTH - 1)) ? '0 : idx_t'(a + 1'b1);
  endfunction

  // Step a physical store index backwards, wrapping at the start of the store.
  function automatic idx_t idx_dec(input idx_t a);
    return (a == '0) ? IDX_W'(DEPTH - 1) : idx_t'(a - 1'b1);
  endfunction

endpackage

// File: rtl/olist_if.sv
// Channel interfaces of the list engine: command input and result output.
interface olist_in_if
  import olist_pkg::*;
();
  logic  valid;
  logic  ready;
  kind_t kind;
  word_t value;
  word_t key;

  modport source (output valid, output kind, output value, output key, input ready);
  modport sink   (input valid, input kind, input value, input key, output ready);
endinterface

interface olist_out_if
  import olist_pkg::*;
();
  logic  valid;
  logic  ready;
  stat_t status;
  word_t removed_value;
  logic  found;
  pos_t  match_position;

  modport source (output valid, output status, output removed_value, output found,
                  output match_position, input ready);
  modport sink   (input valid, input status, input removed_value, input found,
                  input match_position, output ready);
endinterface

// File: rtl/ordered_list_engine_unit.sv
// Top level of the ordered list engine: sequencer, circular store and result register.
//
//   Channel   Direction  Handshake           Payload
//   in_ch     input      valid / ready       kind, value, key
//   out_ch    output     valid / ready       status, removed_value, found, match_position
//
// Insert and trivial cases pass through dispatch and done; delete head and delete tail
// also read the removed entry; key commands scan the list for the key and then, for
// the deletes, close up the entries behind the removed one. The store has a single
// read port that reads one entry per cycle.
// Reset is synchronous and active low; it empties the list, the store contents stay.
// A finished result waits in the output register while the next command is taken;
// a command is refused while the engine is busy.
module ordered_list_engine_unit
  import olist_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  olist_in_if.sink    in_ch,
  olist_out_if.source out_ch
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_REM0  = 3'd3;
  localparam logic [2:0] S_REM1  = 3'd4;
  localparam logic [2:0] S_SHIFT = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  // Control registers.
  logic [2:0] state_r, state_nxt;
  idx_t       head_r, head_nxt;
  cnt_t       count_r, count_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       cmp_vld_r, cmp_vld_nxt;

  // Command and working registers.
  kind_t kind_r;
  word_t value_r, key_r;
  cnt_t  iss_r, iss_nxt;
  cnt_t  cmp_pos_r, cmp_pos_nxt;
  cnt_t  cur_r, cur_nxt;
  idx_t  rp_r, rp_nxt;
  idx_t  wp_r, wp_nxt;

  // Result registers.
  stat_t res_status_r, res_status_nxt;
  word_t res_removed_r, res_removed_nxt;
  logic  res_found_r, res_found_nxt;
  pos_t  res_pos_r, res_pos_nxt;
  stat_t out_status_r, out_status_nxt;
  word_t out_removed_r, out_removed_nxt;
  logic  out_found_r, out_found_nxt;
  pos_t  out_pos_r, out_pos_nxt;

  // Store and its ports.
  word_t mem [DEPTH];
  word_t rdata_r;
  logic  re, we;
  idx_t  raddr, waddr;
  word_t wdata;

  // Shared offset adder: logical position to physical store index.
  cnt_t                 off_sel;
  logic [CNT_W:0]       phys_sum;
  idx_t                 phys_idx;

  logic in_xfer, match;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign match       = cmp_vld_r && (rdata_r == key_r);

  assign phys_sum = {1'b0, {(CNT_W - IDX_W){1'b0}}, head_r} + {1'b0, off_sel};
  assign phys_idx = (phys_sum >= (CNT_W + 1)'(DEPTH))
                    ? IDX_W'(phys_sum - (CNT_W + 1)'(DEPTH))
                    : IDX_W'(phys_sum);

  // Offset fed to the shared adder: the tail for delete tail, a neighbour of the match
  // for the key deletes.
  always_comb begin
    off_sel = count_r - 1'b1;
    if (state_r == S_SCAN) begin
      off_sel = (kind_r == K_DEL_AFT) ? cnt_t'(cmp_pos_r + 1'b1) : cnt_t'(cmp_pos_r - 1'b1);
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    count_nxt       = count_r;
    out_valid_nxt   = out_valid_r;
    cmp_vld_nxt     = cmp_vld_r;
    iss_nxt         = iss_r;
    cmp_pos_nxt     = cmp_pos_r;
    cur_nxt         = cur_r;
    rp_nxt          = rp_r;
    wp_nxt          = wp_r;
    res_status_nxt  = res_status_r;
    res_removed_nxt = res_removed_r;
    res_found_nxt   = res_found_r;
    res_pos_nxt     = res_pos_r;
    out_status_nxt  = out_status_r;
    out_removed_nxt = out_removed_r;
    out_found_nxt   = out_found_r;
    out_pos_nxt     = out_pos_r;
    re    = 1'b0;
    raddr = rp_r;
    we    = 1'b0;
    waddr = wp_r;
    wdata = rdata_r;

    // The output register is emptied by a transfer on the result channel.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_DISP;
        end
      end

      S_DISP: begin
        res_status_nxt  = ST_OK;
        res_removed_nxt = '0;
        res_found_nxt   = 1'b0;
        res_pos_nxt     = '0;
        state_nxt       = S_DONE;
        case (kind_r)
          K_INS_HEAD: begin
            if (count_r == CNT_W'(DEPTH)) begin
              res_status_nxt = ST_FULL;
            end else begin
              we        = 1'b1;
              waddr     = idx_dec(head_r);
              wdata     = value_r;
              head_nxt  = idx_dec(head_r);
              count_nxt = cnt_t'(count_r + 1'b1);
            end
          end
          K_DEL_HEAD, K_DEL_TAIL: begin
            if (count_r == '0) begin
              res_status_nxt = ST_UNDERFLOW;
            end else begin
              cur_nxt   = (kind_r == K_DEL_HEAD) ? '0 : cnt_t'(count_r - 1'b1);
              rp_nxt    = (kind_r == K_DEL_HEAD) ? head_r : phys_idx;
              state_nxt = S_REM0;
            end
          end
          K_DEL_AFT, K_DEL_BEF, K_SEARCH: begin
            iss_nxt     = '0;
            cmp_vld_nxt = 1'b0;
            rp_nxt      = head_r;
            state_nxt   = S_SCAN;
          end
          default: begin
            res_status_nxt = ST_OK;
          end
        endcase
      end

      // One read issued and one compare made each cycle until a match or the end of the list.
      S_SCAN: begin
        if (match) begin
          res_found_nxt = 1'b1;
          res_pos_nxt   = POS_W'(cmp_pos_r);
          state_nxt     = S_DONE;
          if (kind_r == K_DEL_AFT) begin
            if ({1'b0, cmp_pos_r} + 1'b1 >= {1'b0, count_r}) begin
              res_status_nxt = ST_NONEIGH;
            end else begin
              cur_nxt   = cnt_t'(cmp_pos_r + 1'b1);
              rp_nxt    = phys_idx;
              state_nxt = S_REM0;
            end
          end else if (kind_r == K_DEL_BEF) begin
            if (cmp_pos_r == '0) begin
              res_status_nxt = ST_NONEIGH;
            end else begin
              cur_nxt   = cnt_t'(cmp_pos_r - 1'b1);
              rp_nxt    = phys_idx;
              state_nxt = S_REM0;
            end
          end
        end else if (iss_r < count_r) begin
          re          = 1'b1;
          raddr       = rp_r;
          rp_nxt      = idx_inc(rp_r);
          cmp_vld_nxt = 1'b1;
          cmp_pos_nxt = iss_r;
          iss_nxt     = cnt_t'(iss_r + 1'b1);
        end else begin
          res_status_nxt = ST_NOTFOUND;
          cmp_vld_nxt    = 1'b0;
          state_nxt      = S_DONE;
        end
      end

      // Read the entry that leaves the list.
      S_REM0: begin
        re        = 1'b1;
        raddr     = rp_r;
        wp_nxt    = rp_r;
        rp_nxt    = idx_inc(rp_r);
        state_nxt = S_REM1;
      end

      // Capture the removed word; the head moves, otherwise the entries behind close up.
      S_REM1: begin
        res_removed_nxt = rdata_r;
        if (kind_r == K_DEL_HEAD) begin
          head_nxt  = idx_inc(head_r);
          count_nxt = cnt_t'(count_r - 1'b1);
          state_nxt = S_DONE;
        end else if ({1'b0, cur_r} + 1'b1 < {1'b0, count_r}) begin
          re        = 1'b1;
          raddr     = rp_r;
          rp_nxt    = idx_inc(rp_r);
          state_nxt = S_SHIFT;
        end else begin
          count_nxt = cnt_t'(count_r - 1'b1);
          state_nxt = S_DONE;
        end
      end

      // Write each entry one place nearer the head while reading the next one.
      S_SHIFT: begin
        we      = 1'b1;
        waddr   = wp_r;
        wdata   = rdata_r;
        wp_nxt  = idx_inc(wp_r);
        cur_nxt = cnt_t'(cur_r + 1'b1);
        if ({1'b0, cur_r} + 2'd2 < {1'b0, count_r}) begin
          re     = 1'b1;
          raddr  = rp_r;
          rp_nxt = idx_inc(rp_r);
        end else begin
          count_nxt = cnt_t'(count_r - 1'b1);
          state_nxt = S_DONE;
        end
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_removed_nxt = res_removed_r;
          out_found_nxt   = res_found_r;
          out_pos_nxt     = res_pos_r;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_r  <= in_ch.kind;
      value_r <= in_ch.value;
      key_r   <= in_ch.key;
    end
    iss_r         <= iss_nxt;
    cmp_pos_r     <= cmp_pos_nxt;
    cur_r         <= cur_nxt;
    rp_r          <= rp_nxt;
    wp_r          <= wp_nxt;
    res_status_r  <= res_status_nxt;
    res_removed_r <= res_removed_nxt;
    res_found_r   <= res_found_nxt;
    res_pos_r     <= res_pos_nxt;
    out_status_r  <= out_status_nxt;
    out_removed_r <= out_removed_nxt;
    out_found_r   <= out_found_nxt;
    out_pos_r     <= out_pos_nxt;
  end

  // Store: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.removed_value  = out_removed_r;
  assign out_ch.found          = out_found_r;
  assign out_ch.match_position = out_pos_r;

  // The list never holds more entries than the store.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above store depth");

  // An insert into a list with room grows it by one entry.
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_ch.kind == K_INS_HEAD && count_r != CNT_W'(DEPTH))
    |=> ##1 (count_r == cnt_t'($past(count_r, 2) + 1'b1)))
    else $error("insert did not grow the list");

  // An underflow result carries no removed word and no match.
  a_underflow_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_UNDERFLOW)
    |-> (out_removed_r == '0 && !out_found_r))
    else $error("underflow result carries data");

  // The scan never issues a read beyond the tail.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (iss_r <= count_r))
    else $error("scan ran past the tail");

endmodule
